// ----- hdl/pcm16_pkg.sv -----
// Shared types, register indexes and format decode for the PCM to s16 converter.
package pcm16_pkg;

  localparam int unsigned RawW    = 64;
  localparam int unsigned SampleW = 16;
  localparam int unsigned WidthW  = 7;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 8;

  localparam logic [CfgIdxW-1:0] RegKind  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegWidth = 8'd1;

  localparam logic KindInt   = 1'b0;
  localparam logic KindFloat = 1'b1;

  localparam logic [WidthW-1:0] KindWidthReset = 7'd16;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S24 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4,
    FMT_F64 = 3'd5,
    FMT_BAD = 3'd6
  } fmt_e;

  function automatic fmt_e decode_fmt(input logic kind, input logic [WidthW-1:0] width);
    fmt_e f;
    f = FMT_BAD;
    if (kind == KindInt) begin
      unique case (width)
        7'd8:    f = FMT_U8;
        7'd16:   f = FMT_S16;
        7'd24:   f = FMT_S24;
        7'd32:   f = FMT_S32;
        default: f = FMT_BAD;
      endcase
    end else begin
      unique case (width)
        7'd32:   f = FMT_F32;
        7'd64:   f = FMT_F64;
        default: f = FMT_BAD;
      endcase
    end
    return f;
  endfunction

endpackage

// ----- hdl/pcm_sample_to_16bit_converter.sv -----
// Top level: PCM sample to signed 16-bit converter with config registers.
//
// Usage:
//   Input transaction: raw_sample_i is taken at a rising edge where start_i is
//   high and busy_o is low. busy_o stays low, so one sample per cycle is taken.
//   Result: sample_out_o and format_error_o are shown for one cycle with done_o
//   high, once the sample has passed the input register and the result
//   register. The receiver cannot stall; every result is taken in the cycle it
//   appears.
//   Throughput: 1 sample per cycle. Path: input register, then the
//   conversion logic into the result register.
//   Config: cfg_valid_i/cfg_ready_o write channel. Index 0 is the sample kind
//   (0 integer, 1 float), index 1 the sample width. Other indexes are dropped.
//   Write config only while no sample is in flight.
//   Reset: kind 0, width 16, no results pending.
//   Unsupported kind/width pairs give 0 with format_error_o set.
module pcm_sample_to_16bit_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [pcm16_pkg::RawW-1:0]           raw_sample_i,
  output logic                                 done_o,
  output logic signed [pcm16_pkg::SampleW-1:0] sample_out_o,
  output logic                                 format_error_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pcm16_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pcm16_pkg::CfgDatW-1:0]        cfg_data_i
);

  logic                                 kind_q;
  logic [pcm16_pkg::WidthW-1:0]         width_q;
  logic                                 in_vld_q;
  logic [pcm16_pkg::RawW-1:0]           raw_q;
  pcm16_pkg::fmt_e                      fmt_q;
  logic                                 accept;
  logic signed [pcm16_pkg::SampleW-1:0] flt_res;
  logic signed [pcm16_pkg::SampleW-1:0] res_d;
  logic                                 err_d;
  logic                                 out_vld_q;
  logic signed [pcm16_pkg::SampleW-1:0] res_q;
  logic                                 err_q;
  logic [15:0]                          u8_wide;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= pcm16_pkg::KindInt;
      width_q <= pcm16_pkg::KindWidthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pcm16_pkg::RegKind) begin
        kind_q <= cfg_data_i[0];
      end else if (cfg_index_i == pcm16_pkg::RegWidth) begin
        width_q <= cfg_data_i[pcm16_pkg::WidthW-1:0];
      end
    end
  end

  // Input register: format is decoded at capture time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= raw_sample_i;
      fmt_q <= pcm16_pkg::decode_fmt(kind_q, width_q);
    end
  end

  pcm16_float_conv u_flt (
    .raw_i    (raw_q),
    .is_f64_i (fmt_q == pcm16_pkg::FMT_F64),
    .sample_o (flt_res)
  );

  assign u8_wide = {raw_q[7:0], raw_q[7:0]} - 16'h8000;

  always_comb begin
    err_d = 1'b0;
    unique case (fmt_q)
      pcm16_pkg::FMT_U8:                    res_d = $signed(u8_wide);
      pcm16_pkg::FMT_S16:                   res_d = $signed(raw_q[15:0]);
      pcm16_pkg::FMT_S24:                   res_d = $signed(raw_q[23:8]);
      pcm16_pkg::FMT_S32:                   res_d = $signed(raw_q[31:16]);
      pcm16_pkg::FMT_F32, pcm16_pkg::FMT_F64: res_d = flt_res;
      default: begin
        res_d = '0;
        err_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
      err_q <= err_d;
    end
  end

  assign done_o         = out_vld_q;
  assign sample_out_o   = res_q;
  assign format_error_o = err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && format_error_o) |-> (sample_out_o == 16'sd0))
    else $error("error result with nonzero sample");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted sample produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, 2)) |-> $past(accept, 2))
    else $error("result without accepted sample");

endmodule

// ----- hdl/pcm16_float_conv.sv -----
// IEEE float to s16: scale by 32767, round to input precision, truncate, saturate.
module pcm16_float_conv (
  input  logic [pcm16_pkg::RawW-1:0]           raw_i,
  input  logic                                 is_f64_i,
  output logic signed [pcm16_pkg::SampleW-1:0] sample_o
);

  localparam int unsigned QW = 68;
  localparam int unsigned RW = 55;

  logic               sgn;
  logic [10:0]        efld;
  logic               exp_ones;
  logic               exp_zero;
  logic               frac_nz;
  logic [51:0]        frac;
  logic signed [12:0] e_unb;
  logic [52:0]        mant;
  logic [QW-1:0]      q;
  logic [5:0]         drop;
  logic [QW-1:0]      rmask;
  logic [QW-1:0]      kept;
  logic               rnd_bit;
  logic               sticky;
  logic               rnd_up;
  logic [RW-1:0]      r;
  logic signed [12:0] n;
  logic [RW-1:0]      mag;
  logic               sat;

  always_comb begin
    if (is_f64_i) begin
      sgn      = raw_i[63];
      efld     = raw_i[62:52];
      frac     = raw_i[51:0];
      exp_ones = (raw_i[62:52] == 11'h7FF);
      exp_zero = (raw_i[62:52] == 11'h000);
      e_unb    = $signed({2'b00, efld}) - 13'sd1023;
    end else begin
      sgn      = raw_i[31];
      efld     = {3'b000, raw_i[30:23]};
      frac     = {raw_i[22:0], 29'd0};
      exp_ones = (raw_i[30:23] == 8'hFF);
      exp_zero = (raw_i[30:23] == 8'h00);
      e_unb    = $signed({2'b00, efld}) - 13'sd127;
    end
    frac_nz = |frac;
    mant    = {1'b1, frac};
    // x * 32767 == (x << 15) - x
    q       = {mant, 15'd0} - {15'd0, mant};
    drop    = (is_f64_i ? 6'd14 : 6'd43) + {5'd0, q[QW-1]};
    rmask   = {{(QW-1){1'b0}}, 1'b1} << (drop - 6'd1);
    kept    = q >> drop;
    rnd_bit = |(q & rmask);
    sticky  = |(q & (rmask - {{(QW-1){1'b0}}, 1'b1}));
    rnd_up  = rnd_bit & (sticky | kept[0]);
    r       = kept[RW-1:0] + {{(RW-1){1'b0}}, rnd_up};
    n       = 13'sd52 - $signed({7'd0, drop}) - e_unb;
    mag     = '0;
    sat     = 1'b0;
    if (e_unb > 13'sd15) begin
      sat = 1'b1;
    end else if (e_unb < -13'sd16) begin
      mag = '0;
    end else if (n <= 13'sd0) begin
      sat = 1'b1;
    end else begin
      mag = r >> n[5:0];
    end

    if (exp_ones && frac_nz) begin
      sample_o = -16'sd32768;
    end else if (exp_zero) begin
      sample_o = '0;
    end else if (exp_ones || sat) begin
      sample_o = sgn ? -16'sd32768 : 16'sd32767;
    end else if (!sgn) begin
      sample_o = (mag > 55'd32767) ? 16'sd32767 : $signed(mag[15:0]);
    end else begin
      sample_o = (mag >= 55'd32768) ? -16'sd32768 : -$signed(mag[15:0]);
    end
  end

endmodule
